// ===== sv/sil_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted insert list package
// Widths, codes and the command and status bundles shared by the controller,
// the datapath and the top level.
// ----------------------------------------------------------------------------
package sil_pkg;

   // Number of entries the list can hold.
   localparam int CAPACITY = 32;

   // A readout emits at most this many responses.
   localparam int MAX_RESULTS = 32;
   localparam int READ_LIMIT  = (CAPACITY < MAX_RESULTS) ? CAPACITY : MAX_RESULTS;

   // Internal widths that follow from the capacity.
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);

   // Fixed field widths.
   localparam int KIND_W   = 2;
   localparam int CODE_W   = 32;
   localparam int STATUS_W = 3;
   localparam int POS_W    = 5;
   localparam int COUNT_W  = 6;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

   // Response status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED = 3'd0,
      ST_FULL     = 3'd1,
      ST_READ     = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_CLEARED  = 3'd4
   } status_type;

   // Controller states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_SHIFT,
      S_READ
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       capture;        // latch the new code and the compare vector
      logic       shift;          // open a slot and write the code
      logic       clear;          // empty the list
      logic       idx_clr;        // restart the readout index
      logic       idx_inc;        // advance the readout index
      logic       load_rsp;       // load the response register
      logic       rsp_from_entry; // response carries the indexed entry
      status_type rsp_status;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic full;
      logic empty;
      logic read_last;
   } stat_type;

endpackage

// ===== sv/sorted_insert_list_unit.sv =====
// Insert: compare and capture on accept, then shift in S_SHIFT once the response register is
// free; no request is taken meanwhile. Read: one entry per cycle via the entry select
// while the response register is free. Full insert, empty read and clear: response valid the
// cycle after accept. A held response blocks new requests until the consumer takes it.
// Synchronous active-high reset empties the list and drops any pending response.
// ----------------------------------------------------------------------------
// Sorted insert list unit
// Bounded list of signed codes kept in ascending order, with insert, ordered
// readout and clear requests.
// ----------------------------------------------------------------------------
module sorted_insert_list_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [sil_pkg::KIND_W-1:0]          req_kind,
   input  logic signed [sil_pkg::CODE_W-1:0]   req_new_code,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sil_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [sil_pkg::CODE_W-1:0]   rsp_entry_value,
   output logic [sil_pkg::POS_W-1:0]           rsp_entry_position,
   output logic [sil_pkg::COUNT_W-1:0]         rsp_count_now,
   output logic                                rsp_last
);

   sil_pkg::cmd_type  cmd;
   sil_pkg::stat_type stat;

   // Request sequencing.
   sil_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Entry storage and response payload.
   sil_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_new_code       (req_new_code),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_status         (rsp_status),
      .rsp_entry_value    (rsp_entry_value),
      .rsp_entry_position (rsp_entry_position),
      .rsp_count_now      (rsp_count_now),
      .rsp_last           (rsp_last)
   );

endmodule

// ===== sv/sil_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sorted insert list controller
// State machine that accepts requests, sequences inserts and readouts, and
// owns the response valid flag.
// ----------------------------------------------------------------------------
module sil_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [sil_pkg::KIND_W-1:0]      req_kind,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  sil_pkg::stat_type               stat,
   output sil_pkg::cmd_type                cmd
);

   sil_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   // The response register can take a new response when empty or being drained.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   // State and response valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sil_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         sil_pkg::S_IDLE: begin
            req_stall = !out_free;
            // A request is taken when the response register can receive its answer.
            if (req_valid && out_free) begin
               case (req_kind)
                  sil_pkg::KIND_INSERT: begin
                     if (stat.full) begin
                        cmd.load_rsp   = 1'b1;
                        cmd.rsp_status = sil_pkg::ST_FULL;
                     end else begin
                        cmd.capture = 1'b1;
                        state_in    = sil_pkg::S_SHIFT;
                     end
                  end
                  sil_pkg::KIND_READ: begin
                     if (stat.empty) begin
                        cmd.load_rsp   = 1'b1;
                        cmd.rsp_status = sil_pkg::ST_EMPTY;
                     end else begin
                        cmd.idx_clr = 1'b1;
                        state_in    = sil_pkg::S_READ;
                     end
                  end
                  sil_pkg::KIND_CLEAR: begin
                     cmd.clear      = 1'b1;
                     cmd.load_rsp   = 1'b1;
                     cmd.rsp_status = sil_pkg::ST_CLEARED;
                  end
                  default: begin
                     // A reserved kind changes nothing and gives no response.
                     state_in = sil_pkg::S_IDLE;
                  end
               endcase
            end
         end
         sil_pkg::S_SHIFT: begin
            if (out_free) begin
               cmd.shift      = 1'b1;
               cmd.load_rsp   = 1'b1;
               cmd.rsp_status = sil_pkg::ST_INSERTED;
               state_in       = sil_pkg::S_IDLE;
            end
         end
         sil_pkg::S_READ: begin
            if (out_free) begin
               cmd.load_rsp       = 1'b1;
               cmd.rsp_from_entry = 1'b1;
               cmd.rsp_status     = sil_pkg::ST_READ;
               cmd.idx_inc        = 1'b1;
               if (stat.read_last) begin
                  state_in = sil_pkg::S_IDLE;
               end
            end
         end
         default: begin
            state_in = sil_pkg::S_IDLE;
         end
      endcase
   end

   // A loaded response stays until the consumer takes it.
   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

endmodule

// ===== sv/sil_datapath.sv =====
// ----------------------------------------------------------------------------
// Sorted insert list datapath
// Row of entry cells that compare in parallel and shift to open a slot, the
// entry count, the readout index and the response payload register.
// ----------------------------------------------------------------------------
module sil_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [sil_pkg::CODE_W-1:0]   req_new_code,
   input  sil_pkg::cmd_type                    cmd,
   output sil_pkg::stat_type                   stat,
   output logic [sil_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [sil_pkg::CODE_W-1:0]   rsp_entry_value,
   output logic [sil_pkg::POS_W-1:0]           rsp_entry_position,
   output logic [sil_pkg::COUNT_W-1:0]         rsp_count_now,
   output logic                                rsp_last
);

   logic signed [sil_pkg::CODE_W-1:0] entries_ff [sil_pkg::CAPACITY];
   logic signed [sil_pkg::CODE_W-1:0] code_ff;
   logic [sil_pkg::CAPACITY-1:0]      lt_ff, lt_in;
   logic [sil_pkg::CNT_W-1:0]         count_ff, count_in;
   logic [sil_pkg::IDX_W-1:0]         idx_ff;
   logic [sil_pkg::CNT_W-1:0]         read_n;

   logic [sil_pkg::STATUS_W-1:0]      status_ff;
   logic signed [sil_pkg::CODE_W-1:0] value_ff;
   logic [sil_pkg::POS_W-1:0]         position_ff;
   logic [sil_pkg::COUNT_W-1:0]       count_now_ff;
   logic                              last_ff;

   // Each cell compares its held code with the incoming one; the result is a
   // run of ones over the held entries that are smaller.
   // The cells also shift: a cell past the slot takes its left neighbor,
   // and the cell at the slot takes the new code.
   for (genvar i = 0; i < sil_pkg::CAPACITY; i++) begin : g_cell
      assign lt_in[i] = (sil_pkg::CNT_W'(i) < count_ff) && (entries_ff[i] < req_new_code);

      if (i == 0) begin : g_head
         always_ff @(posedge clock) begin
            if (cmd.shift && !lt_ff[i]) begin
               entries_ff[i] <= code_ff;
            end
         end
      end else begin : g_body
         always_ff @(posedge clock) begin
            if (cmd.shift && !lt_ff[i]) begin
               entries_ff[i] <= lt_ff[i-1] ? code_ff : entries_ff[i-1];
            end
         end
      end
   end

   // Code and compare vector are held for the shift cycle.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         code_ff <= req_new_code;
         lt_ff   <= lt_in;
      end
   end

   // Entry count.
   always_comb begin
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.shift) begin
         count_in = count_ff + sil_pkg::CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Readout index.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.idx_clr) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + sil_pkg::IDX_W'(1);
      end
   end

   // A readout covers the held entries, up to the response limit.
   assign read_n = (count_ff > sil_pkg::CNT_W'(sil_pkg::READ_LIMIT)) ?
                   sil_pkg::CNT_W'(sil_pkg::READ_LIMIT) : count_ff;

   assign stat.full      = (count_ff == sil_pkg::CNT_W'(sil_pkg::CAPACITY));
   assign stat.empty     = (count_ff == '0);
   assign stat.read_last = ((sil_pkg::CNT_W'(idx_ff) + sil_pkg::CNT_W'(1)) == read_n);

   // Response payload register.
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         status_ff    <= cmd.rsp_status;
         count_now_ff <= sil_pkg::COUNT_W'(count_in);
         if (cmd.rsp_from_entry) begin
            value_ff    <= entries_ff[idx_ff];
            position_ff <= sil_pkg::POS_W'(idx_ff);
            last_ff     <= stat.read_last;
         end else begin
            value_ff    <= '0;
            position_ff <= '0;
            last_ff     <= 1'b1;
         end
      end
   end

   assign rsp_status         = status_ff;
   assign rsp_entry_value    = value_ff;
   assign rsp_entry_position = position_ff;
   assign rsp_count_now      = count_now_ff;
   assign rsp_last           = last_ff;

endmodule

// ===== sv/sil_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted insert list checker
// Port-level assertions on the response channel and the request stall, bound to the top level.
// ----------------------------------------------------------------------------
module sil_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [sil_pkg::STATUS_W-1:0]        rsp_status,
   input logic signed [sil_pkg::CODE_W-1:0]   rsp_entry_value,
   input logic [sil_pkg::POS_W-1:0]           rsp_entry_position,
   input logic [sil_pkg::COUNT_W-1:0]         rsp_count_now,
   input logic                                rsp_last
);

   // A stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_entry_value) && $stable(rsp_entry_position) &&
      $stable(rsp_count_now) && $stable(rsp_last))
      else $error("stalled response changed");

   // No request is taken while a response is blocked.
   a_no_take_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request accepted while response blocked");

   // Only entry responses carry a value and a position, and all others end a request.
   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != sil_pkg::ST_READ) |->
      rsp_last && (rsp_entry_value == '0) && (rsp_entry_position == '0))
      else $error("non-entry response malformed");

   // Clear and empty responses report an empty list.
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_status == sil_pkg::ST_CLEARED) ||
      (rsp_status == sil_pkg::ST_EMPTY)) |-> (rsp_count_now == '0))
      else $error("count not zero after clear or empty read");

endmodule

bind sorted_insert_list_unit sil_checker u_sil_checker (.*);

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Sorted insert list unit testbench
// Drives insert, readout, clear and reserved requests into the list with
// random gaps and response back-pressure. A behavioral copy of the ordered
// list predicts every response, and each accepted response is checked field
// by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

   // The one request kind that the block ignores.
   localparam logic [sil_pkg::KIND_W-1:0] KIND_RESERVED = 2'd3;

   // Cycles without any handshake before the run is declared hung.
   localparam int STALL_LIMIT = 4000;

   typedef logic signed [sil_pkg::CODE_W-1:0] code_type;

   typedef struct {
      sil_pkg::status_type         status;
      code_type                    value;
      logic [sil_pkg::POS_W-1:0]   position;
      logic [sil_pkg::COUNT_W-1:0] count;
      logic                        last;
   } list_result_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [sil_pkg::KIND_W-1:0]   req_kind = sil_pkg::KIND_INSERT;
   code_type                     req_new_code = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [sil_pkg::STATUS_W-1:0] rsp_status;
   code_type                     rsp_entry_value;
   logic [sil_pkg::POS_W-1:0]    rsp_entry_position;
   logic [sil_pkg::COUNT_W-1:0]  rsp_count_now;
   logic                         rsp_last;

   // Shadow copy of the list and the responses it predicts.
   code_type        shadow_list[$];
   list_result_type pending_results[$];

   int fail_count    = 0;
   int req_gap_pct   = 0;
   int rsp_stall_pct = 0;
   int hold_ask      = 0;
   int hold_left     = 0;
   int idle_cycles   = 0;

   sorted_insert_list_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_new_code       (req_new_code),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_entry_value    (rsp_entry_value),
      .rsp_entry_position (rsp_entry_position),
      .rsp_count_now      (rsp_count_now),
      .rsp_last           (rsp_last)
   );

   always #5 clock = ~clock;

   // Queue one predicted response.
   task automatic push_result(sil_pkg::status_type status, code_type value,
                              int position, logic last);
      list_result_type r;
      r.status   = status;
      r.value    = value;
      r.position = position[sil_pkg::POS_W-1:0];
      r.count    = sil_pkg::COUNT_W'(shadow_list.size());
      r.last     = last;
      pending_results.push_back(r);
   endtask

   // Apply one accepted request to the shadow list and predict its responses.
   task automatic predict_list_op(logic [sil_pkg::KIND_W-1:0] kind, code_type code);
      int slot;
      int n;
      case (kind)
         sil_pkg::KIND_INSERT: begin
            if (shadow_list.size() >= sil_pkg::CAPACITY) begin
               push_result(sil_pkg::ST_FULL, '0, 0, 1'b1);
            end else begin
               // A new code lands ahead of any equal codes already held.
               slot = 0;
               while (slot < shadow_list.size() && shadow_list[slot] < code) slot++;
               shadow_list.insert(slot, code);
               push_result(sil_pkg::ST_INSERTED, '0, 0, 1'b1);
            end
         end
         sil_pkg::KIND_READ: begin
            n = (shadow_list.size() > sil_pkg::MAX_RESULTS) ? sil_pkg::MAX_RESULTS
                                                             : shadow_list.size();
            if (n == 0) begin
               push_result(sil_pkg::ST_EMPTY, '0, 0, 1'b1);
            end
            for (int i = 0; i < n; i++) begin
               push_result(sil_pkg::ST_READ, shadow_list[i], i, i + 1 == n);
            end
         end
         sil_pkg::KIND_CLEAR: begin
            shadow_list.delete();
            push_result(sil_pkg::ST_CLEARED, '0, 0, 1'b1);
         end
         default: begin
            // Reserved kind: no state change and no response.
         end
      endcase
   endtask

   // Offer one request, starting and ending at a falling edge.
   task automatic send_request(logic [sil_pkg::KIND_W-1:0] kind, code_type code);
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_new_code <= code;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_list_op(kind, code);
      @(negedge clock);
   endtask

   // Random code, biased toward duplicates and the ends of the range.
   function automatic code_type pick_code();
      case ($urandom_range(3))
         0: return $urandom();
         1: return $signed($urandom_range(16)) - 8;
         2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(3)
                                           : 32'h8000_0000 + $urandom_range(3);
      endcase
   endfunction

   // Mostly inserts so the list grows deep; reads, clears and noise between.
   task automatic send_random_request();
      int r;
      r = $urandom_range(99);
      if (r < 74) send_request(sil_pkg::KIND_INSERT, pick_code());
      else if (r < 90) send_request(sil_pkg::KIND_READ, $urandom());
      else if (r < 93) send_request(sil_pkg::KIND_CLEAR, $urandom());
      else send_request(KIND_RESERVED, $urandom());
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // Field extremes, duplicates, empty list and the reserved kind.
   task automatic test_directed();
      send_request(sil_pkg::KIND_READ, '0);
      send_request(sil_pkg::KIND_CLEAR, '1);
      send_request(sil_pkg::KIND_INSERT, 32'sd5);
      send_request(sil_pkg::KIND_INSERT, 32'sd5);
      send_request(sil_pkg::KIND_INSERT, 32'h7FFF_FFFF);
      send_request(sil_pkg::KIND_INSERT, 32'h8000_0000);
      send_request(sil_pkg::KIND_INSERT, -32'sd1);
      send_request(sil_pkg::KIND_INSERT, 32'sd0);
      send_request(KIND_RESERVED, 32'hFFFF_FFFF);
      send_request(sil_pkg::KIND_READ, '1);
      send_request(sil_pkg::KIND_INSERT, 32'h7FFF_FFFF);
      send_request(sil_pkg::KIND_INSERT, 32'h8000_0000);
      send_request(sil_pkg::KIND_INSERT, 32'hAAAA_AAAA);
      send_request(sil_pkg::KIND_INSERT, 32'h5555_5555);
      send_request(sil_pkg::KIND_READ, '0);
      send_request(sil_pkg::KIND_CLEAR, '0);
      send_request(sil_pkg::KIND_READ, '0);
      send_request(KIND_RESERVED, '0);
      send_request(sil_pkg::KIND_INSERT, 32'sd1);
      send_request(sil_pkg::KIND_READ, '0);
      send_request(sil_pkg::KIND_CLEAR, '0);
   endtask

   // Fill the list, overflow it, then read all of it out.
   task automatic test_full_list();
      send_request(sil_pkg::KIND_CLEAR, '0);
      for (int i = 0; i < sil_pkg::CAPACITY; i++) begin
         send_request(sil_pkg::KIND_INSERT, pick_code());
      end
      send_request(sil_pkg::KIND_INSERT, 32'h8000_0000);
      send_request(sil_pkg::KIND_INSERT, $urandom());
      send_request(sil_pkg::KIND_READ, '0);
      send_request(KIND_RESERVED, $urandom());
      send_request(sil_pkg::KIND_READ, '0);
      send_request(sil_pkg::KIND_CLEAR, '0);
      send_request(sil_pkg::KIND_READ, '0);
   endtask

   task automatic test_random(int count, int gap_pct, int stall_pct);
      req_gap_pct   = gap_pct;
      rsp_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) send_random_request();
   endtask

   // Long response hold-off fills the block, then the sender waits it out.
   task automatic test_backpressure();
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      hold_ask      = 200;
      for (int i = 0; i < 8; i++) send_request(sil_pkg::KIND_INSERT, pick_code());
      send_request(sil_pkg::KIND_READ, '0);
      wait_drained();
      @(negedge clock);
      send_request(sil_pkg::KIND_INSERT, $urandom());
      send_request(sil_pkg::KIND_READ, '0);
      send_request(sil_pkg::KIND_CLEAR, '0);
   endtask

   // Response side back-pressure, with an optional long hold-off.
   always @(negedge clock) begin
      if (hold_ask != 0) begin
         hold_left = hold_ask;
         hold_ask  = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Compare each accepted response with the oldest prediction.
   always @(posedge clock) begin : check_response
      list_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("unexpected response: status %0d value %0d", rsp_status, rsp_entry_value);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               fail_count++;
            end
            if (rsp_entry_value !== want.value) begin
               $error("entry_value: expected %0d, got %0d", want.value, rsp_entry_value);
               fail_count++;
            end
            if (rsp_entry_position !== want.position) begin
               $error("entry_position: expected %0d, got %0d",
                      want.position, rsp_entry_position);
               fail_count++;
            end
            if (rsp_count_now !== want.count) begin
               $error("count_now: expected %0d, got %0d", want.count, rsp_count_now);
               fail_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on cycles with no handshake on either side.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("sorted_insert_list_unit regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      req_gap_pct   = 38;
      rsp_stall_pct = 78;
      test_directed();
      test_full_list();
      test_random(32, 38, 78);
      test_random(32, 78, 38);
      test_random(33, 0, 0);
      test_backpressure();

      // Let the last responses drain, then allow for any trailing work.
      wait_drained();
      repeat (40) @(posedge clock);
      if (pending_results.size() == 0 && fail_count == 0) begin
         $display("sorted_insert_list_unit regression: pass");
      end else begin
         $display("sorted_insert_list_unit regression: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/sil_pkg.sv
sv/sil_ctrl.sv
sv/sil_datapath.sv
sv/sorted_insert_list_unit.sv
sv/sil_checker.sv
sim/testbench.sv
